// ===== rtl/hssc_pkg.sv =====
// Shared types, codes and helpers for the hall six-step commutator.
`timescale 1ns / 1ps

package hssc_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int HALL_W     = 3;
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 3;
    localparam int SPEED_W    = 24;
    localparam int PHASE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int HALL_TBL_W = 32;
    localparam int COMM_TBL_W = 36;
    localparam int ENTRY_W    = 4;
    localparam int EN_W       = 6;

    // Speed numerator and serial divider length
    localparam logic [SPEED_W-1:0] SPEED_NUM = 24'd10_000_000;
    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Last step of the six-step cycle
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_HALL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MANUAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALL_TBL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMM_TBL  = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } hssc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic load_out;
    } hssc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_result;
        logic needs_div;
        logic div_done;
        logic out_free;
    } hssc_stat_t;

    // Move one step with (reverse) or against (forward) the cycle, wrapping
    function automatic logic [STEP_W-1:0] advance(input logic dir,
                                                  input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        if (dir)
        begin
            r = (s >= STEP_LAST) ? '0 : s + 3'd1;
        end
        else
        begin
            r = (s == '0 || s > STEP_LAST) ? STEP_LAST : s - 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hssc_ctrl.sv =====
// Controller state machine: accept, divide, deliver.
`timescale 1ns / 1ps

module hssc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hssc_pkg::hssc_stat_t stat,
    output hssc_pkg::hssc_cmd_t  cmd
);

    hssc_pkg::hssc_state_t state_reg;
    hssc_pkg::hssc_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hssc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one word at a time
    always_comb
    begin
        state_next   = state_reg;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            hssc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (!stat.has_result)
                    begin
                        state_next = hssc_pkg::ST_IDLE;
                    end
                    else if (stat.needs_div)
                    begin
                        state_next = hssc_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = hssc_pkg::ST_DONE;
                    end
                end
            end
            hssc_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = hssc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            hssc_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = hssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hssc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/hssc_datapath.sv =====
// Datapath: registers, step logic, serial speed divider, output word.
`timescale 1ns / 1ps

module hssc_datapath #(
    parameter int PWM_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hssc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [hssc_pkg::CMD_W-1:0]             command,
    input  logic [hssc_pkg::HALL_W-1:0]            hall_bits,
    input  logic [hssc_pkg::TIME_W-1:0]            time_us,
    input  hssc_pkg::hssc_cmd_t                    cmd,
    output hssc_pkg::hssc_stat_t                   stat,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_a_first,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_a_second,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_b_first,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_b_second,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_c_first,
    output logic [hssc_pkg::PHASE_W-1:0]           phase_c_second,
    output logic [hssc_pkg::STEP_W-1:0]            active_step,
    output logic [hssc_pkg::SPEED_W-1:0]           speed_value,
    output logic                                   speed_updated
);

    localparam int PhaseW = hssc_pkg::PHASE_W;
    localparam int TimeW  = hssc_pkg::TIME_W;

    // Configuration
    logic                              direction_reg;
    logic [PWM_WIDTH-1:0]              pwm_low_reg;
    logic [PWM_WIDTH-1:0]              pwm_high_reg;
    logic [hssc_pkg::HALL_TBL_W-1:0]   hall_table_reg;
    logic [hssc_pkg::COMM_TBL_W-1:0]   comm_table_reg;

    // Motor state
    logic [TimeW-1:0]                  last_zero_time_reg;
    logic [hssc_pkg::SPEED_W-1:0]      speed_reg;
    logic [hssc_pkg::STEP_W-1:0]       manual_counter_reg;

    // Word in flight
    logic [hssc_pkg::STEP_W-1:0]       step_reg;
    logic                              off_reg;
    logic                              updated_reg;

    // Serial divider
    logic [TimeW-1:0]                  divisor_reg;
    logic [TimeW-1:0]                  rem_reg;
    logic [hssc_pkg::SPEED_W-1:0]      num_reg;
    logic [hssc_pkg::SPEED_W-1:0]      quo_reg;
    logic [hssc_pkg::DIV_CNT_W-1:0]    div_cnt_reg;

    logic                              out_valid_reg;

    // Combinational helpers
    logic [hssc_pkg::ENTRY_W-1:0]      entry;
    logic                              entry_ok;
    logic [hssc_pkg::STEP_W-1:0]       hall_step;
    logic [hssc_pkg::STEP_W-1:0]       manual_adv;
    logic [hssc_pkg::STEP_W-1:0]       new_step;
    logic [TimeW-1:0]                  interval;
    logic [TimeW:0]                    trial;
    logic                              fits;
    logic [hssc_pkg::EN_W-1:0]         en;
    logic [PhaseW-1:0]                 hi_lvl;
    logic [PhaseW-1:0]                 lo_lvl;

    // Decode the incoming word
    always_comb
    begin
        entry       = hall_table_reg[{hall_bits, 2'b00} +: hssc_pkg::ENTRY_W];
        entry_ok    = (entry <= 4'(hssc_pkg::STEP_LAST));
        hall_step   = hssc_pkg::advance(direction_reg, entry[hssc_pkg::STEP_W-1:0]);
        manual_adv  = hssc_pkg::advance(direction_reg, manual_counter_reg);
        case (command)
            hssc_pkg::CMD_HALL:   new_step = hall_step;
            hssc_pkg::CMD_MANUAL: new_step = manual_adv;
            default:              new_step = '0;
        endcase
        stat.has_result = (command == hssc_pkg::CMD_HALL) ? entry_ok
                        : (command == hssc_pkg::CMD_MANUAL || command == hssc_pkg::CMD_OFF);
        stat.needs_div  = (command == hssc_pkg::CMD_HALL) && entry_ok && (hall_step == '0);
        stat.div_done   = (div_cnt_reg == '0);
        stat.out_free   = !out_valid_reg || !out_stall;
        // Zero interval counts as one microsecond
        interval = time_us - last_zero_time_reg;
        if (interval == '0)
        begin
            interval = TimeW'(1);
        end
    end

    // Restoring division step
    always_comb
    begin
        trial = {rem_reg, num_reg[hssc_pkg::SPEED_W-1]};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= 1'b0;
            pwm_low_reg    <= '0;
            pwm_high_reg   <= '0;
            hall_table_reg <= '0;
            comm_table_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                hssc_pkg::REG_DIRECTION: direction_reg  <= cfg_data[0];
                hssc_pkg::REG_PWM_LOW:   pwm_low_reg    <= cfg_data[PWM_WIDTH-1:0];
                hssc_pkg::REG_PWM_HIGH:  pwm_high_reg   <= cfg_data[PWM_WIDTH-1:0];
                hssc_pkg::REG_HALL_TBL:  hall_table_reg <= cfg_data[hssc_pkg::HALL_TBL_W-1:0];
                hssc_pkg::REG_COMM_TBL:  comm_table_reg <= cfg_data[hssc_pkg::COMM_TBL_W-1:0];
                default: ;
            endcase
        end
    end

    // Update motor state and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_zero_time_reg <= '0;
            speed_reg          <= '0;
            manual_counter_reg <= '0;
            div_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.take && command == hssc_pkg::CMD_MANUAL)
            begin
                manual_counter_reg <= manual_adv;
            end
            if (cmd.take && stat.needs_div)
            begin
                last_zero_time_reg <= time_us;
                div_cnt_reg        <= hssc_pkg::DIV_CNT_W'(hssc_pkg::DIV_STEPS);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - hssc_pkg::DIV_CNT_W'(1);
            end
            if (cmd.load_out && updated_reg)
            begin
                speed_reg <= quo_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the word and run the divider
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            step_reg    <= new_step;
            off_reg     <= (command == hssc_pkg::CMD_OFF);
            updated_reg <= stat.needs_div;
            divisor_reg <= interval;
            rem_reg     <= '0;
            num_reg     <= hssc_pkg::SPEED_NUM;
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? TimeW'(trial - {1'b0, divisor_reg}) : trial[TimeW-1:0];
            num_reg <= {num_reg[hssc_pkg::SPEED_W-2:0], 1'b0};
            quo_reg <= {quo_reg[hssc_pkg::SPEED_W-2:0], fits};
        end
    end

    // Pick the channel enables of the current step
    always_comb
    begin
        case (step_reg)
            3'd0:    en = comm_table_reg[5:0];
            3'd1:    en = comm_table_reg[11:6];
            3'd2:    en = comm_table_reg[17:12];
            3'd3:    en = comm_table_reg[23:18];
            3'd4:    en = comm_table_reg[29:24];
            3'd5:    en = comm_table_reg[35:30];
            default: en = '0;
        endcase
        if (off_reg)
        begin
            en = '0;
        end
        hi_lvl = PhaseW'(pwm_high_reg);
        lo_lvl = PhaseW'(pwm_low_reg);
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            phase_a_first  <= en[0] ? hi_lvl : '0;
            phase_a_second <= en[1] ? lo_lvl : '0;
            phase_b_first  <= en[2] ? hi_lvl : '0;
            phase_b_second <= en[3] ? lo_lvl : '0;
            phase_c_first  <= en[4] ? hi_lvl : '0;
            phase_c_second <= en[5] ? lo_lvl : '0;
            active_step    <= step_reg;
            speed_value    <= off_reg ? '0 : (updated_reg ? quo_reg : speed_reg);
            speed_updated  <= updated_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/hall_six_step_commutator.sv =====
// Top level of the hall six-step commutator.
//
//   channel  direction  handshake            contents
//   in       to block   in_valid / in_stall  command, hall_bits, time_us
//   out      from block out_valid / out_stall six phase levels, step, speed
//   cfg      to block   cfg_write_en         cfg_index, cfg_data
//
// A manual step, an off word or a hall edge off step 0 goes from idle to done.
// A hall edge landing on step 0 also passes the divide state: the speed comes
// from a restoring divider producing one quotient bit per cycle over 24 bits.
// A word with no result leaves the block idle. Reset clears the control,
// configuration and motor state registers at once; a waiting output word
// holds under out_stall while the next input word is still taken and worked on.
`timescale 1ns / 1ps

module hall_six_step_commutator #(
    parameter int PWM_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hssc_pkg::CMD_W-1:0]          command,
    input  logic [hssc_pkg::HALL_W-1:0]         hall_bits,
    input  logic [hssc_pkg::TIME_W-1:0]         time_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_a_first,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_a_second,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_b_first,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_b_second,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_c_first,
    output logic [hssc_pkg::PHASE_W-1:0]        phase_c_second,
    output logic [hssc_pkg::STEP_W-1:0]         active_step,
    output logic [hssc_pkg::SPEED_W-1:0]        speed_value,
    output logic                                speed_updated
);

    hssc_pkg::hssc_cmd_t  cmd;
    hssc_pkg::hssc_stat_t stat;

    // Sequence words
    hssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Compute steps, speed and levels
    hssc_datapath #(
        .PWM_WIDTH (PWM_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .hall_bits      (hall_bits),
        .time_us        (time_us),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_a_first  (phase_a_first),
        .phase_a_second (phase_a_second),
        .phase_b_first  (phase_b_first),
        .phase_b_second (phase_b_second),
        .phase_c_first  (phase_c_first),
        .phase_c_second (phase_c_second),
        .active_step    (active_step),
        .speed_value    (speed_value),
        .speed_updated  (speed_updated)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hall six-step commutator.
`timescale 1ns / 1ps

module tb_top;

    // Command code that the block drops without a word out
    localparam logic [hssc_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
    // Longer than the divide of a step-0 edge
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_NS = 4_000_000;

    typedef struct packed {
        logic [hssc_pkg::PHASE_W-1:0] a_first;
        logic [hssc_pkg::PHASE_W-1:0] a_second;
        logic [hssc_pkg::PHASE_W-1:0] b_first;
        logic [hssc_pkg::PHASE_W-1:0] b_second;
        logic [hssc_pkg::PHASE_W-1:0] c_first;
        logic [hssc_pkg::PHASE_W-1:0] c_second;
        logic [hssc_pkg::STEP_W-1:0]  step;
        logic [hssc_pkg::SPEED_W-1:0] speed;
        logic                         updated;
    } drive_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write_en = 1'b0;
    logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [hssc_pkg::CMD_W-1:0]      command = hssc_pkg::CMD_HALL;
    logic [hssc_pkg::HALL_W-1:0]     hall_bits = '0;
    logic [hssc_pkg::TIME_W-1:0]     time_us = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [hssc_pkg::PHASE_W-1:0]    phase_a_first;
    logic [hssc_pkg::PHASE_W-1:0]    phase_a_second;
    logic [hssc_pkg::PHASE_W-1:0]    phase_b_first;
    logic [hssc_pkg::PHASE_W-1:0]    phase_b_second;
    logic [hssc_pkg::PHASE_W-1:0]    phase_c_first;
    logic [hssc_pkg::PHASE_W-1:0]    phase_c_second;
    logic [hssc_pkg::STEP_W-1:0]     active_step;
    logic [hssc_pkg::SPEED_W-1:0]    speed_value;
    logic                            speed_updated;

    // Register copies
    logic                            dir_q = 1'b0;
    logic [hssc_pkg::PHASE_W-1:0]    pwm_lo_q = '0;
    logic [hssc_pkg::PHASE_W-1:0]    pwm_hi_q = '0;
    logic [hssc_pkg::HALL_TBL_W-1:0] hall_tbl_q = '0;
    logic [hssc_pkg::COMM_TBL_W-1:0] comm_tbl_q = '0;

    // Motor state copies
    logic [hssc_pkg::TIME_W-1:0]     last_zero_us = '0;
    logic [hssc_pkg::SPEED_W-1:0]    speed_q = '0;
    logic [hssc_pkg::STEP_W-1:0]     manual_cnt_q = '0;

    drive_word_t                     pending_drive[$];
    int                              mismatch_count = 0;
    bit                              idle_on = 1'b1;
    int                              hold_left = 0;
    int                              burst_left = 0;
    logic [hssc_pkg::TIME_W-1:0]     clock_us = '0;

    hall_six_step_commutator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .hall_bits      (hall_bits),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_a_first  (phase_a_first),
        .phase_a_second (phase_a_second),
        .phase_b_first  (phase_b_first),
        .phase_b_second (phase_b_second),
        .phase_c_first  (phase_c_first),
        .phase_c_second (phase_c_second),
        .active_step    (active_step),
        .speed_value    (speed_value),
        .speed_updated  (speed_updated)
    );

    always #4 clk = ~clk;

    // Move one step with the cycle in reverse, against it going forward
    function automatic logic [hssc_pkg::STEP_W-1:0] next_step(
        input logic [hssc_pkg::STEP_W-1:0] s);
        if (dir_q)
            return (s == hssc_pkg::STEP_LAST) ? 3'd0 : s + 3'd1;
        return (s == 3'd0) ? hssc_pkg::STEP_LAST : s - 3'd1;
    endfunction

    // Gate the PWM levels through the enables of step s
    function automatic drive_word_t phase_levels(input logic [hssc_pkg::STEP_W-1:0] s,
                                                 input logic fresh);
        drive_word_t               w;
        logic [hssc_pkg::EN_W-1:0] en;
        en = comm_tbl_q[hssc_pkg::EN_W*s +: hssc_pkg::EN_W];
        w.a_first  = en[0] ? pwm_hi_q : '0;
        w.a_second = en[1] ? pwm_lo_q : '0;
        w.b_first  = en[2] ? pwm_hi_q : '0;
        w.b_second = en[3] ? pwm_lo_q : '0;
        w.c_first  = en[4] ? pwm_hi_q : '0;
        w.c_second = en[5] ? pwm_lo_q : '0;
        w.step     = s;
        w.speed    = speed_q;
        w.updated  = fresh;
        return w;
    endfunction

    // Advance the motor state for one command; return 1 when a word comes out
    function automatic bit commutate(input logic [hssc_pkg::CMD_W-1:0] cmd,
                                     input logic [hssc_pkg::HALL_W-1:0] hall,
                                     input logic [hssc_pkg::TIME_W-1:0] now_us,
                                     output drive_word_t w);
        logic [hssc_pkg::ENTRY_W-1:0] entry;
        logic [hssc_pkg::STEP_W-1:0]  s;
        logic [hssc_pkg::TIME_W-1:0]  span_us;
        logic [hssc_pkg::TIME_W-1:0]  quo;
        logic                         fresh;
        w = '0;
        if (cmd == hssc_pkg::CMD_HALL)
        begin
            entry = hall_tbl_q[hssc_pkg::ENTRY_W*hall +: hssc_pkg::ENTRY_W];
            // drop codes that the table marks invalid
            if (entry > hssc_pkg::STEP_LAST)
                return 1'b0;
            s = next_step(entry[hssc_pkg::STEP_W-1:0]);
            fresh = 1'b0;
            // recompute speed on every step-0 edge, a zero interval counts as one
            if (s == 3'd0)
            begin
                span_us = now_us - last_zero_us;
                if (span_us == '0)
                    span_us = 32'd1;
                quo = hssc_pkg::SPEED_NUM / span_us;
                speed_q = quo[hssc_pkg::SPEED_W-1:0];
                last_zero_us = now_us;
                fresh = 1'b1;
            end
            w = phase_levels(s, fresh);
            return 1'b1;
        end
        if (cmd == hssc_pkg::CMD_MANUAL)
        begin
            manual_cnt_q = next_step(manual_cnt_q);
            w = phase_levels(manual_cnt_q, 1'b0);
            return 1'b1;
        end
        return cmd == hssc_pkg::CMD_OFF;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Offer one word, with a random gap ahead of it, and hold it until taken
    task automatic send_word(input logic [hssc_pkg::CMD_W-1:0] cmd,
                             input logic [hssc_pkg::HALL_W-1:0] hall,
                             input logic [hssc_pkg::TIME_W-1:0] now_us);
        drive_word_t w;
        int          gap;
        gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        command   = cmd;
        hall_bits = hall;
        time_us   = now_us;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (commutate(cmd, hall, now_us, w))
            pending_drive.push_back(w);
    endtask

    // Drop valid, wait out every pending word and let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drive.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [hssc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hssc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            hssc_pkg::REG_DIRECTION: dir_q      = value[0];
            hssc_pkg::REG_PWM_LOW:   pwm_lo_q   = value[hssc_pkg::PHASE_W-1:0];
            hssc_pkg::REG_PWM_HIGH:  pwm_hi_q   = value[hssc_pkg::PHASE_W-1:0];
            hssc_pkg::REG_HALL_TBL:  hall_tbl_q = value[hssc_pkg::HALL_TBL_W-1:0];
            hssc_pkg::REG_COMM_TBL:  comm_tbl_q = value[hssc_pkg::COMM_TBL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic dir, input logic [hssc_pkg::PHASE_W-1:0] lo,
                               input logic [hssc_pkg::PHASE_W-1:0] hi,
                               input logic [hssc_pkg::HALL_TBL_W-1:0] htbl,
                               input logic [hssc_pkg::COMM_TBL_W-1:0] ctbl);
        wait_idle();
        write_reg(hssc_pkg::REG_DIRECTION, 36'(dir));
        write_reg(hssc_pkg::REG_PWM_LOW, 36'(lo));
        write_reg(hssc_pkg::REG_PWM_HIGH, 36'(hi));
        write_reg(hssc_pkg::REG_HALL_TBL, 36'(htbl));
        write_reg(hssc_pkg::REG_COMM_TBL, ctbl);
    endtask

    function automatic logic [hssc_pkg::PHASE_W-1:0] pick_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Six valid codes in a shuffled order, the all-low and all-high codes invalid
    function automatic logic [hssc_pkg::HALL_TBL_W-1:0] make_hall_table();
        logic [hssc_pkg::HALL_TBL_W-1:0] t;
        int                              order[6];
        int                              j;
        int                              k;
        int                              tmp;
        for (j = 0; j < 6; j++)
            order[j] = j;
        for (j = 5; j > 0; j--)
        begin
            k = $urandom_range(j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        t = '0;
        for (j = 0; j < 6; j++)
            t[hssc_pkg::ENTRY_W*(j+1) +: hssc_pkg::ENTRY_W] = 4'(order[j]);
        t[3:0]   = 4'($urandom_range(15, 6));
        t[31:28] = 4'($urandom_range(15, 6));
        return t;
    endfunction

    // Mostly valid hall edges on a running clock, plus manual, off and noise words
    task automatic random_traffic(input int n);
        logic [hssc_pkg::HALL_W-1:0] hall;
        logic [hssc_pkg::TIME_W-1:0] gap_us;
        int                          i;
        int                          pick;
        int                          tries;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            hall = 3'($urandom);
            if (pick < 10)
                send_word(2'($urandom_range(3)), hall, $urandom);
            else if (pick < 70)
            begin
                tries = 0;
                while (hall_tbl_q[hssc_pkg::ENTRY_W*hall +: hssc_pkg::ENTRY_W]
                       > hssc_pkg::STEP_LAST && tries < 8)
                begin
                    hall = 3'($urandom);
                    tries++;
                end
                case ($urandom_range(9))
                    0:       gap_us = '0;
                    1:       gap_us = $urandom;
                    2, 3, 4: gap_us = $urandom_range(100, 1);
                    default: gap_us = $urandom_range(2_000_000, 100);
                endcase
                clock_us += gap_us;
                send_word(hssc_pkg::CMD_HALL, hall, clock_us);
            end
            else if (pick < 85)
                send_word(hssc_pkg::CMD_MANUAL, hall, $urandom);
            else if (pick < 93)
                send_word(hssc_pkg::CMD_OFF, hall, $urandom);
            else
                send_word(hssc_pkg::CMD_HALL, hall, clock_us);
        end
    endtask

    // Reset values: table entry 0 everywhere, all enables off
    task automatic test_reset_defaults();
        send_word(hssc_pkg::CMD_HALL, 3'd5, 32'd1234);
        send_word(hssc_pkg::CMD_MANUAL, 3'd0, 32'd0);
        send_word(hssc_pkg::CMD_OFF, 3'd0, 32'd0);
    endtask

    task automatic test_directed_cases();
        int h;
        load_config(1'b0, 16'hFFFF, 16'hFFFF, 32'hF543_210F, 36'hF_FFFF_FFFF);
        // zero interval against the reset timestamp, then again
        send_word(hssc_pkg::CMD_HALL, 3'd2, 32'd0);
        send_word(hssc_pkg::CMD_HALL, 3'd2, 32'd0);
        // longest interval, then across the timestamp wrap
        send_word(hssc_pkg::CMD_HALL, 3'd2, 32'hFFFF_FFFF);
        send_word(hssc_pkg::CMD_HALL, 3'd2, 32'd9);
        // invalid table entries
        send_word(hssc_pkg::CMD_HALL, 3'd0, 32'd100);
        send_word(hssc_pkg::CMD_HALL, 3'd7, 32'd100);
        // every valid code, so every step
        for (h = 1; h <= 6; h++)
            send_word(hssc_pkg::CMD_HALL, 3'(h), 32'd200);
        send_word(CMD_IGNORED, 3'd7, 32'hFFFF_FFFF);
        // manual steps through a full forward wrap
        repeat (6)
            send_word(hssc_pkg::CMD_MANUAL, 3'd0, 32'd0);
        send_word(hssc_pkg::CMD_OFF, 3'd7, 32'hFFFF_FFFF);
        // reverse, all codes invalid, all enables off
        load_config(1'b1, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 36'h0);
        send_word(hssc_pkg::CMD_HALL, 3'd4, 32'd300);
        repeat (2)
            send_word(hssc_pkg::CMD_MANUAL, 3'd5, 32'd0);
        send_word(hssc_pkg::CMD_OFF, 3'd0, 32'd0);
    endtask

    task automatic test_random_settings();
        logic [hssc_pkg::HALL_TBL_W-1:0] htbl;
        logic [hssc_pkg::COMM_TBL_W-1:0] ctbl;
        int                              p;
        clock_us = $urandom;
        for (p = 0; p < 5; p++)
        begin
            htbl = (p == 3) ? $urandom : make_hall_table();
            ctbl = (p == 0) ? '1 : (p == 1) ? '0 : 36'({$urandom, $urandom});
            load_config(p[0], pick_level(), pick_level(), htbl, ctbl);
            random_traffic(90);
        end
    endtask

    task automatic test_output_backpressure();
        load_config(1'($urandom_range(1)), pick_level(), pick_level(), make_hall_table(),
                    36'({$urandom, $urandom}));
        // hold the output long enough that the block backs up into its input
        hold_left = 200;
        random_traffic(40);
        wait_idle();
        random_traffic(20);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        load_config(1'($urandom_range(1)), pick_level(), pick_level(), make_hall_table(),
                    36'({$urandom, $urandom}));
        random_traffic(100);
    endtask

    // Output stall: long hold when asked, else random bursts while idle_on is set
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (burst_left > 0)
        begin
            out_stall = 1'b1;
            burst_left--;
        end
        else if (idle_on && $urandom_range(4) == 0)
        begin
            out_stall = 1'b1;
            burst_left = $urandom_range(3);
        end
        else
            out_stall = 1'b0;
    end

    // Compare each word taken with the oldest pending one
    always @(posedge clk)
    begin
        drive_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive.size() == 0)
                report_mismatch("word with nothing pending, step", 32'(active_step), 32'd0);
            else
            begin
                want = pending_drive.pop_front();
                check_field("phase_a_first", 32'(phase_a_first), 32'(want.a_first));
                check_field("phase_a_second", 32'(phase_a_second), 32'(want.a_second));
                check_field("phase_b_first", 32'(phase_b_first), 32'(want.b_first));
                check_field("phase_b_second", 32'(phase_b_second), 32'(want.b_second));
                check_field("phase_c_first", 32'(phase_c_first), 32'(want.c_first));
                check_field("phase_c_second", 32'(phase_c_second), 32'(want.c_second));
                check_field("active_step", 32'(active_step), 32'(want.step));
                check_field("speed_value", 32'(speed_value), 32'(want.speed));
                check_field("speed_updated", 32'(speed_updated), 32'(want.updated));
            end
        end
    end

    initial
    begin
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed_cases();
        test_random_settings();
        test_output_backpressure();
        test_steady_stream();
        wait_idle();
        if (mismatch_count == 0)
            $display("[hall_six_step_commutator] OK");
        else
            $display("[hall_six_step_commutator] ERROR");
        $finish;
    end

    initial
    begin
        #LIMIT_NS;
        $display("[hall_six_step_commutator] ERROR");
        $finish;
    end

endmodule
